// ----- rtl/crcdf_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the frame deframer.
package crcdf_pkg;

  // Width of the good / bad frame counters (wrapping)
  localparam int unsigned CountWidth = 32;
  // Width of the counter fields in a result
  localparam int unsigned CountOutWidth = 32;
  // Packed width of the result stream tdata (fields plus zero fill to whole bytes)
  localparam int unsigned ResDataBits  = 2 + 6 * 8 + 2 * CountOutWidth;
  localparam int unsigned ResDataWidth = ((ResDataBits + 7) / 8) * 8;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  // Configuration register reset values
  localparam logic [7:0] StartByteRst = 8'd126;
  localparam logic [7:0] MyAddrRst    = 8'd0;
  localparam logic [7:0] BcastAddrRst = 8'd255;

  typedef logic [CountWidth-1:0] count_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgStartByte = 2'd0,
    CfgMyAddr    = 2'd1,
    CfgBcastAddr = 2'd2
  } cfg_idx_e;

  // Parser phases
  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhDst  = 3'd1,
    PhSrc  = 3'd2,
    PhCmd  = 3'd3,
    PhLen  = 3'd4,
    PhPay  = 3'd5,
    PhClo  = 3'd6,
    PhChi  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] my_address;
    logic [7:0] broadcast_address;
  } cfg_t;

  typedef struct packed {
    logic                     frame_end;
    logic                     crc_match;
    logic                     deliver;
    logic                     payload_valid;
    logic [7:0]               payload_byte;
    logic [7:0]               payload_index;
    logic [7:0]               dest_field;
    logic [7:0]               source_field;
    logic [7:0]               command_field;
    logic [7:0]               length_field;
    logic [CountOutWidth-1:0] good_frames;
    logic [CountOutWidth-1:0] bad_crc_frames;
  } result_t;

  // One byte through the CRC, MSB first, eight shift steps
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/crcdf_cfg.sv -----
// Configuration registers: start marker, node address, broadcast address.
module crcdf_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  output crcdf_pkg::cfg_t    cfg_o
);

  crcdf_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; an index past the list is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        crcdf_pkg::CfgStartByte: cfg_d.start_byte        = cfg_wdata_i;
        crcdf_pkg::CfgMyAddr:    cfg_d.my_address        = cfg_wdata_i;
        crcdf_pkg::CfgBcastAddr: cfg_d.broadcast_address = cfg_wdata_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte        <= crcdf_pkg::StartByteRst;
      cfg_q.my_address        <= crcdf_pkg::MyAddrRst;
      cfg_q.broadcast_address <= crcdf_pkg::BcastAddrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/crcdf_parser.sv -----
// Frame parser state machine, running CRC, held header and frame counters.
module crcdf_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,     // consume one item this cycle
  input  logic                 func_i,     // 1 = timeout
  input  logic [7:0]           rx_byte_i,
  input  crcdf_pkg::cfg_t      cfg_i,
  output crcdf_pkg::result_t   result_o    // result of the item at step_i
);

  crcdf_pkg::phase_e phase_q, phase_d;
  logic [7:0]        idx_q, idx_d;
  logic [7:0]        idx_inc;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       crc_next;
  logic [15:0]       crc_rx;
  logic [7:0]        crc_lo_q, crc_lo_d;
  logic [7:0]        dest_q, dest_d;
  logic [7:0]        src_q, src_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        len_q, len_d;
  crcdf_pkg::count_t good_q, good_d;
  crcdf_pkg::count_t bad_q, bad_d;

  assign crc_next = crcdf_pkg::crc16_update(crc_q, rx_byte_i);
  assign idx_inc  = idx_q + 8'd1;
  assign crc_rx   = {rx_byte_i, crc_lo_q};

  // Next state and result for the current item
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    dest_d   = dest_q;
    src_d    = src_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    good_d   = good_q;
    bad_d    = bad_q;

    result_o.frame_end     = 1'b0;
    result_o.crc_match     = 1'b0;
    result_o.deliver       = 1'b0;
    result_o.payload_valid = 1'b0;
    result_o.payload_byte  = 8'd0;
    result_o.payload_index = 8'd0;

    if (func_i) begin
      // timeout: abandon any frame in progress
      if (phase_q != crcdf_pkg::PhHunt) begin
        phase_d = crcdf_pkg::PhHunt;
        idx_d   = 8'd0;
        crc_d   = crcdf_pkg::CrcInit;
      end
    end else begin
      case (phase_q)
        crcdf_pkg::PhHunt: begin
          if (rx_byte_i == cfg_i.start_byte) begin
            crc_d   = crcdf_pkg::CrcInit;
            idx_d   = 8'd0;
            phase_d = crcdf_pkg::PhDst;
          end
        end
        crcdf_pkg::PhDst: begin
          dest_d  = rx_byte_i;
          crc_d   = crc_next;
          phase_d = crcdf_pkg::PhSrc;
        end
        crcdf_pkg::PhSrc: begin
          src_d   = rx_byte_i;
          crc_d   = crc_next;
          phase_d = crcdf_pkg::PhCmd;
        end
        crcdf_pkg::PhCmd: begin
          cmd_d   = rx_byte_i;
          crc_d   = crc_next;
          phase_d = crcdf_pkg::PhLen;
        end
        crcdf_pkg::PhLen: begin
          len_d   = rx_byte_i;
          crc_d   = crc_next;
          idx_d   = 8'd0;
          // empty payload goes straight to the CRC bytes
          phase_d = (rx_byte_i == 8'd0) ? crcdf_pkg::PhClo : crcdf_pkg::PhPay;
        end
        crcdf_pkg::PhPay: begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = rx_byte_i;
          result_o.payload_index = idx_q;
          crc_d = crc_next;
          idx_d = idx_inc;
          if (idx_inc >= len_q) begin
            phase_d = crcdf_pkg::PhClo;
          end
        end
        crcdf_pkg::PhClo: begin
          crc_lo_d = rx_byte_i;
          phase_d  = crcdf_pkg::PhChi;
        end
        crcdf_pkg::PhChi: begin
          result_o.frame_end = 1'b1;
          if (crc_rx != crc_q) begin
            bad_d = bad_q + crcdf_pkg::CountWidth'(1);
          end else begin
            result_o.crc_match = 1'b1;
            good_d = good_q + crcdf_pkg::CountWidth'(1);
            result_o.deliver = (dest_q == cfg_i.my_address) ||
                               (dest_q == cfg_i.broadcast_address);
          end
          phase_d = crcdf_pkg::PhHunt;
          idx_d   = 8'd0;
          crc_d   = crcdf_pkg::CrcInit;
        end
        default: begin
          phase_d = crcdf_pkg::PhHunt;
        end
      endcase
    end

    // header and counters as they stand after this item
    result_o.dest_field     = dest_d;
    result_o.source_field   = src_d;
    result_o.command_field  = cmd_d;
    result_o.length_field   = len_d;
    result_o.good_frames    = crcdf_pkg::CountOutWidth'(good_d);
    result_o.bad_crc_frames = crcdf_pkg::CountOutWidth'(bad_d);
  end

  // Parser state, advances only when an item is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= crcdf_pkg::PhHunt;
      idx_q    <= 8'd0;
      crc_q    <= crcdf_pkg::CrcInit;
      crc_lo_q <= 8'd0;
      dest_q   <= 8'd0;
      src_q    <= 8'd0;
      cmd_q    <= 8'd0;
      len_q    <= 8'd0;
      good_q   <= '0;
      bad_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      dest_q   <= dest_d;
      src_q    <= src_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      good_q   <= good_d;
      bad_q    <= bad_d;
    end
  end

endmodule

// ----- rtl/crc16_frame_deframer.sv -----
// Top level: input register, frame parser, result register and config port.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid / s_axis_tready rx byte, timeout flag in tuser
//   m_axis    out        m_axis_tvalid / m_axis_tready one result per input item
//   cfg       in         cfg_we_i (no back-pressure)   register index and data
//
// One item per cycle sustained while m_axis does not stall; each result passes
// the input register, then the parser logic, into the result register.
// The single-byte CRC update is one XOR network with no register inside it.
// Reset returns the parser to start hunt, clears counters and held
// header bytes, and loads the register defaults. A stall on m_axis holds both
// registers and drops s_axis_tready once the input register is occupied.
module crc16_frame_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
  input  logic                                s_axis_tuser,  // [0] func (1 = timeout)
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] crc_match, [1] deliver, [9:2] payload_byte, [17:10] payload_index,
  // [25:18] dest_field, [33:26] source_field, [41:34] command_field,
  // [49:42] length_field, [81:50] good_frames, [113:82] bad_crc_frames, rest zero
  output logic [crcdf_pkg::ResDataWidth-1:0]  m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] payload_valid
  output logic                                m_axis_tlast,  // frame_end
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [7:0]                          cfg_wdata_i
);

  crcdf_pkg::cfg_t    cfg;
  crcdf_pkg::result_t res_d, res_q;

  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       advance;
  logic       out_valid_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  crcdf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  crcdf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .func_i    (in_func_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.frame_end;
  assign m_axis_tuser  = res_q.payload_valid;
  assign m_axis_tdata  = {
    (crcdf_pkg::ResDataWidth - crcdf_pkg::ResDataBits)'(0),
    res_q.bad_crc_frames,
    res_q.good_frames,
    res_q.length_field,
    res_q.command_field,
    res_q.source_field,
    res_q.dest_field,
    res_q.payload_index,
    res_q.payload_byte,
    res_q.deliver,
    res_q.crc_match
  };

endmodule

// ----- bench/crc16_frame_deframer_tb.sv -----
// Self-checking testbench for the CRC-16 frame deframer: directed frames, then random traffic.
module crc16_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index outside the register list; the block must ignore writes to it
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned RandomItems = 1450;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [7:0]                         s_axis_tdata;   // [7:0] rx_byte
  logic                               s_axis_tuser;   // [0] func (1 = timeout)
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  // [0] crc_match, [1] deliver, [9:2] payload_byte, [17:10] payload_index,
  // [25:18] dest_field, [33:26] source_field, [41:34] command_field,
  // [49:42] length_field, [81:50] good_frames, [113:82] bad_crc_frames, rest zero
  logic [crcdf_pkg::ResDataWidth-1:0] m_axis_tdata;
  logic                               m_axis_tuser;   // [0] payload_valid
  logic                               m_axis_tlast;   // frame_end
  logic                               cfg_we_i;
  logic [1:0]                         cfg_idx_i;
  logic [7:0]                         cfg_wdata_i;

  crc16_frame_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Parser image kept by the bench
  crcdf_pkg::cfg_t   cfg_copy;
  crcdf_pkg::phase_e parse_ph;
  logic [7:0]        pay_pos;
  logic [15:0]       crc_acc;
  logic [7:0]        crc_lo_seen;
  logic [7:0]        dest_seen, src_seen, cmd_seen, len_seen;
  crcdf_pkg::count_t good_cnt, bad_cnt;

  crcdf_pkg::result_t parser_out_q[$];
  int unsigned        mismatches;
  int unsigned        items_sent;
  logic               steady;   // no gaps and no stalls while set

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // CRC-16/CCITT-FALSE, one bit per step, MSB first
  function automatic logic [15:0] ccitt_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? crcdf_pkg::CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  task automatic hunt_again();
    parse_ph = crcdf_pkg::PhHunt;
    pay_pos  = 8'd0;
    crc_acc  = crcdf_pkg::CrcInit;
  endtask

  task automatic parser_reset();
    cfg_copy.start_byte        = crcdf_pkg::StartByteRst;
    cfg_copy.my_address        = crcdf_pkg::MyAddrRst;
    cfg_copy.broadcast_address = crcdf_pkg::BcastAddrRst;
    hunt_again();
    crc_lo_seen = 8'd0;
    dest_seen   = 8'd0;
    src_seen    = 8'd0;
    cmd_seen    = 8'd0;
    len_seen    = 8'd0;
    good_cnt    = '0;
    bad_cnt     = '0;
  endtask

  // Advance the parser image by one accepted transaction and queue its result
  task automatic advance_parser(input logic func, input logic [7:0] b);
    crcdf_pkg::result_t r;
    r = '0;
    if (func) begin
      if (parse_ph != crcdf_pkg::PhHunt) hunt_again();
    end else begin
      case (parse_ph)
        crcdf_pkg::PhHunt: begin
          if (b == cfg_copy.start_byte) begin
            crc_acc  = crcdf_pkg::CrcInit;
            pay_pos  = 8'd0;
            parse_ph = crcdf_pkg::PhDst;
          end
        end
        crcdf_pkg::PhDst: begin
          dest_seen = b;
          crc_acc   = ccitt_step(crc_acc, b);
          parse_ph  = crcdf_pkg::PhSrc;
        end
        crcdf_pkg::PhSrc: begin
          src_seen = b;
          crc_acc  = ccitt_step(crc_acc, b);
          parse_ph = crcdf_pkg::PhCmd;
        end
        crcdf_pkg::PhCmd: begin
          cmd_seen = b;
          crc_acc  = ccitt_step(crc_acc, b);
          parse_ph = crcdf_pkg::PhLen;
        end
        crcdf_pkg::PhLen: begin
          len_seen = b;
          crc_acc  = ccitt_step(crc_acc, b);
          pay_pos  = 8'd0;
          parse_ph = (b == 8'd0) ? crcdf_pkg::PhClo : crcdf_pkg::PhPay;
        end
        crcdf_pkg::PhPay: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = pay_pos;
          crc_acc = ccitt_step(crc_acc, b);
          pay_pos = pay_pos + 8'd1;
          if (pay_pos >= len_seen) parse_ph = crcdf_pkg::PhClo;
        end
        crcdf_pkg::PhClo: begin
          crc_lo_seen = b;
          parse_ph    = crcdf_pkg::PhChi;
        end
        default: begin
          r.frame_end = 1'b1;
          if ({b, crc_lo_seen} != crc_acc) begin
            bad_cnt = bad_cnt + 1'b1;
          end else begin
            r.crc_match = 1'b1;
            good_cnt = good_cnt + 1'b1;
            r.deliver = (dest_seen == cfg_copy.my_address) ||
                        (dest_seen == cfg_copy.broadcast_address);
          end
          hunt_again();
        end
      endcase
    end
    r.dest_field     = dest_seen;
    r.source_field   = src_seen;
    r.command_field  = cmd_seen;
    r.length_field   = len_seen;
    r.good_frames    = crcdf_pkg::CountOutWidth'(good_cnt);
    r.bad_crc_frames = crcdf_pkg::CountOutWidth'(bad_cnt);
    parser_out_q.push_back(r);
  endtask

  // One input transaction, with a random gap in front unless steady
  task automatic send_item(input logic func, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_parser(func, b);
    items_sent++;
  endtask

  // Whole frame with correct CRC xor flip; cut > 0 replaces that byte by a timeout
  task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                            input logic [7:0] cmd, input logic [7:0] len,
                            input logic [15:0] flip, input int unsigned cut);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    frame_q = {cfg_copy.start_byte, dest, src, cmd, len};
    for (int k = 0; k < len; k++) begin
      frame_q.push_back(($urandom_range(0, 7) == 0) ? cfg_copy.start_byte : 8'($urandom));
    end
    crc = crcdf_pkg::CrcInit;
    for (int k = 1; k < frame_q.size(); k++) crc = ccitt_step(crc, frame_q[k]);
    crc = crc ^ flip;
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    for (int k = 0; k < frame_q.size(); k++) begin
      if (cut != 0 && k == cut) begin
        send_item(1'b1, 8'($urandom));
        break;
      end
      send_item(1'b0, frame_q[k]);
    end
  endtask

  // Let every queued result come back, then wait with the input idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (parser_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      crcdf_pkg::CfgStartByte: cfg_copy.start_byte        = value;
      crcdf_pkg::CfgMyAddr:    cfg_copy.my_address        = value;
      crcdf_pkg::CfgBcastAddr: cfg_copy.broadcast_address = value;
      default:                 ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Default registers: timeout and noise while hunting, good, broadcast and bad-CRC frames
  task automatic test_reset_config();
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_frame(8'h00, 8'hFF, 8'h00, 8'd0, 16'h0000, 0);
    // start byte value inside the header is plain data
    send_frame(8'hFF, crcdf_pkg::StartByteRst, 8'hFF, 8'd1, 16'h0000, 0);
    send_frame(8'h55, 8'hAA, 8'h01, 8'd0, 16'h8001, 0);
  endtask

  // Extreme register values, ignored index, timeout inside a frame
  task automatic test_config_writes();
    wait_idle();
    write_reg(crcdf_pkg::CfgStartByte, 8'h00);
    write_reg(crcdf_pkg::CfgMyAddr, 8'hFF);
    write_reg(crcdf_pkg::CfgBcastAddr, 8'h00);
    write_reg(CfgUnused, 8'h5A);
    send_frame(8'hFF, 8'h00, 8'h80, 8'd2, 16'h0000, 0);
    send_frame(8'h00, 8'h01, 8'h02, 8'd3, 16'h0000, 3);
    send_frame(8'h00, 8'h7F, 8'hFE, 8'd0, 16'h0000, 0);
    send_frame(8'h12, 8'h34, 8'h56, 8'd1, 16'h0000, 0);
    send_item(1'b1, 8'h00);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  dest;
    logic [7:0]  len;
    logic [15:0] flip;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    dest = (pick < 40) ? cfg_copy.my_address :
           (pick < 60) ? cfg_copy.broadcast_address : 8'($urandom);
    pick = $urandom_range(0, 99);
    len  = (pick < 90) ? 8'($urandom_range(0, 8)) :
           (pick < 98) ? 8'($urandom_range(9, 40)) : 8'd255;
    flip = (kind >= 70 && kind < 80) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    cut  = (kind >= 80 && kind < 88) ? $urandom_range(1, len + 6) : 0;
    if (kind < 88) begin
      send_frame(dest, 8'($urandom), 8'($urandom), len, flip, cut);
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom));
      send_item(1'b1, 8'($urandom));
    end else begin
      send_item(1'b1, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(crcdf_pkg::CfgStartByte, 8'hFF);
          write_reg(crcdf_pkg::CfgMyAddr, 8'h00);
          write_reg(crcdf_pkg::CfgBcastAddr, 8'hFF);
        end
        3: begin
          write_reg(crcdf_pkg::CfgStartByte, 8'($urandom));
          write_reg(crcdf_pkg::CfgMyAddr, 8'($urandom));
          write_reg(crcdf_pkg::CfgBcastAddr, cfg_copy.my_address);
        end
        default: begin
          write_reg(crcdf_pkg::CfgStartByte, 8'($urandom));
          write_reg(crcdf_pkg::CfgMyAddr, 8'($urandom));
          write_reg(crcdf_pkg::CfgBcastAddr, 8'($urandom));
        end
      endcase
      steady = (ph == 2);
      goal = items_sent + RandomItems / 6;
      while (items_sent < goal) send_random_frame();
      steady = 1'b0;
    end
  endtask

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  // Compare each result transaction against the oldest prediction
  always @(posedge clk_i) begin : check_results
    crcdf_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.frame_end      = m_axis_tlast;
      got.crc_match      = m_axis_tdata[0];
      got.deliver        = m_axis_tdata[1];
      got.payload_valid  = m_axis_tuser;
      got.payload_byte   = m_axis_tdata[9:2];
      got.payload_index  = m_axis_tdata[17:10];
      got.dest_field     = m_axis_tdata[25:18];
      got.source_field   = m_axis_tdata[33:26];
      got.command_field  = m_axis_tdata[41:34];
      got.length_field   = m_axis_tdata[49:42];
      got.good_frames    = m_axis_tdata[81:50];
      got.bad_crc_frames = m_axis_tdata[113:82];
      if (parser_out_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'h0, 32'h1);
      end else begin
        want = parser_out_q.pop_front();
        check_field("frame_end", want.frame_end, got.frame_end);
        check_field("crc_match", want.crc_match, got.crc_match);
        check_field("deliver", want.deliver, got.deliver);
        check_field("payload_valid", want.payload_valid, got.payload_valid);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("payload_index", want.payload_index, got.payload_index);
        check_field("dest_field", want.dest_field, got.dest_field);
        check_field("source_field", want.source_field, got.source_field);
        check_field("command_field", want.command_field, got.command_field);
        check_field("length_field", want.length_field, got.length_field);
        check_field("good_frames", want.good_frames, got.good_frames);
        check_field("bad_crc_frames", want.bad_crc_frames, got.bad_crc_frames);
        check_field("tdata fill", 32'h0,
                    32'(m_axis_tdata[crcdf_pkg::ResDataWidth-1:crcdf_pkg::ResDataBits]));
      end
    end
  end

  initial begin
    mismatches    = 0;
    items_sent    = 0;
    steady        = 1'b0;
    parser_reset();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= crcdf_pkg::CfgStartByte;
    cfg_wdata_i   <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_config_writes();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && parser_out_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
